@@ rtl/core/crc_msb_first_multi_width_unit_assert.svh @@
// assertion macros shared by the crc unit rtl
`ifndef CRC_MSB_FIRST_MULTI_WIDTH_UNIT_ASSERT_SVH
`define CRC_MSB_FIRST_MULTI_WIDTH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CRCMW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crc unit check failed");

// next-cycle implication, sampled on clock, off during reset
`define CRCMW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crc unit check failed");

`endif

@@ rtl/core/crcmw_pkg.sv @@
// shared types and constants for the multi-width msb-first crc unit
`timescale 1ns / 1ps
`default_nettype none

package crcmw_pkg;

   localparam int CRC_MAX_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // width select codes, anything else means 32 bits
   localparam logic [1:0] WIDTH_SEL_8  = 2'd0;
   localparam logic [1:0] WIDTH_SEL_16 = 2'd1;
   localparam logic [1:0] WIDTH_SEL_32 = 2'd2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH_SELECT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATOR_POLY = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_VALUE  = 2'd2;

   localparam logic [1:0]               RESET_WIDTH_SELECT   = WIDTH_SEL_32;
   localparam logic [CRC_MAX_WIDTH-1:0] RESET_GENERATOR_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_MAX_WIDTH-1:0] RESET_INITIAL_VALUE  = 32'h0000_0000;

   typedef struct packed {
      logic [1:0]               width_select;
      logic [CRC_MAX_WIDTH-1:0] generator_poly;
      logic [CRC_MAX_WIDTH-1:0] initial_value;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/core/crcmw_csr.sv @@
// configuration registers of the crc unit
`timescale 1ns / 1ps
`default_nettype none

module crcmw_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]    csr_write_data,
   output crcmw_pkg::cfg_type                          cfg
);

   crcmw_pkg::cfg_type cfg_ff;
   crcmw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            crcmw_pkg::CSR_WIDTH_SELECT: begin
               cfg_in.width_select = csr_write_data[1:0];
            end
            crcmw_pkg::CSR_GENERATOR_POLY: begin
               cfg_in.generator_poly = csr_write_data;
            end
            crcmw_pkg::CSR_INITIAL_VALUE: begin
               cfg_in.initial_value = csr_write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_select   <= crcmw_pkg::RESET_WIDTH_SELECT;
         cfg_ff.generator_poly <= crcmw_pkg::RESET_GENERATOR_POLY;
         cfg_ff.initial_value  <= crcmw_pkg::RESET_INITIAL_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/crcmw_update.sv @@
// one-byte crc update: seed select, byte merge and eight xor-shift steps
`timescale 1ns / 1ps
`default_nettype none

module crcmw_update (
   input  wire crcmw_pkg::cfg_type                   cfg,
   input  wire logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]  running_crc,
   input  wire logic [7:0]                           data_byte,
   input  wire logic                                 first_byte,
   output logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]       crc_next
);

   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] mask;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] top;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] seed;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] merged;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] poly;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc;

   always_comb begin
      case (cfg.width_select)
         crcmw_pkg::WIDTH_SEL_8: begin
            mask = 32'h0000_00FF;
            top  = 32'h0000_0080;
         end
         crcmw_pkg::WIDTH_SEL_16: begin
            mask = 32'h0000_FFFF;
            top  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            top  = 32'h8000_0000;
         end
      endcase
   end

   always_comb begin
      seed = (first_byte ? cfg.initial_value : running_crc) & mask;
      poly = cfg.generator_poly & mask;
      // byte goes into the top eight bits of the active width
      case (cfg.width_select)
         crcmw_pkg::WIDTH_SEL_8:  merged = seed ^ {24'd0, data_byte};
         crcmw_pkg::WIDTH_SEL_16: merged = seed ^ {16'd0, data_byte, 8'd0};
         default:                 merged = seed ^ {data_byte, 24'd0};
      endcase
   end

   always_comb begin
      crc = merged;
      for (int k = 0; k < 8; k++) begin
         if ((crc & top) != '0) begin
            crc = ((crc << 1) ^ poly) & mask;
         end else begin
            crc = (crc << 1) & mask;
         end
      end
      crc_next = crc;
   end

endmodule

`default_nettype wire

@@ rtl/core/crc_msb_first_multi_width_unit.sv @@
// top level of the byte-serial msb-first crc unit
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial CRC, MSB first, non-reflected, no final XOR, 8/16/32 bits wide
// with programmable polynomial and initial value (csr index 0 width select,
// 1 polynomial, 2 initial value; write them only while no item is in flight).
// An accepted item waits in the input register and the eight xor-shift steps
// update the running CRC as it leaves; one item per cycle is sustained,
// limited by the running CRC feedback through that combinational update,
// unless a last item waits behind a stalled result. A last item puts the
// CRC into the result register as it leaves, and the next item is still
// taken while that result waits. A first item reloads the initial value;
// without it the CRC continues from the previous value (zero after reset).

`include "crc_msb_first_multi_width_unit_assert.svh"

module crc_msb_first_multi_width_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [7:0]                             req_data_byte,
   input  wire logic                                   req_first_byte,
   input  wire logic                                   req_last_byte,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]         rsp_crc_value,
   input  wire logic                                   csr_write_enable,
   input  wire logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]    csr_write_data
);

   crcmw_pkg::cfg_type cfg;

   logic                                in_valid_ff;
   logic                                in_valid_in;
   logic [7:0]                          in_byte_ff;
   logic                                in_first_ff;
   logic                                in_last_ff;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] running_crc_ff;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] running_crc_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] rsp_crc_ff;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] rsp_crc_in;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc_next;
   logic                                out_free;
   logic                                in_advance;
   logic                                req_take;
   logic                                rsp_load;

   crcmw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   crcmw_update u_update (
      .cfg         (cfg),
      .running_crc (running_crc_ff),
      .data_byte   (in_byte_ff),
      .first_byte  (in_first_ff),
      .crc_next    (crc_next)
   );

   // an item without last never needs the result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall  = in_valid_ff && !in_advance;
   assign req_take   = req_valid && !req_stall;
   assign rsp_load   = in_advance && in_last_ff;

   always_comb begin
      in_valid_in    = in_valid_ff;
      running_crc_in = running_crc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_crc_in     = rsp_crc_ff;
      if (in_advance) begin
         in_valid_in    = 1'b0;
         running_crc_in = crc_next;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = crc_next;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
      end
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   `CRCMW_ASSERT_IMP(a_stall_only_on_blocked_last,
      req_stall, in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall)
   `CRCMW_ASSERT_IMP(a_plain_item_never_stalls,
      in_valid_ff && !in_last_ff, !req_stall)
   `CRCMW_ASSERT_NXT(a_last_item_gives_result,
      rsp_load, rsp_valid && rsp_crc_value == $past(crc_next))
   `CRCMW_ASSERT_NXT(a_crc_follows_update,
      in_advance, running_crc_ff == $past(crc_next))

endmodule

`default_nettype wire

@@ verif/crc_msb_first_multi_width_unit_tb.sv @@
// self-checking testbench for the byte-serial msb-first crc unit
`timescale 1ns / 1ps

module crc_msb_first_multi_width_unit_tb;

   // index 3 decodes to no register
   localparam logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEM_TARGET = 390;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {GAPS_RX_HEAVY, GAPS_TX_HEAVY, GAPS_NONE} gap_mode_type;

   typedef struct {
      row_kind_type                          kind;
      logic [7:0]                            data;
      logic                                  first;
      logic                                  last;
      logic                                  known;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]   value;
      logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0] index;
   } stim_row_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [7:0]                            req_data_byte;
   logic                                  req_first_byte;
   logic                                  req_last_byte;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]   rsp_crc_value;
   logic                                  csr_write_enable;
   logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0]   csr_write_data;

   // shadow of the block's registers and running crc
   logic [1:0]                          cur_width_sel;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] cur_poly;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] cur_init;
   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc_state;

   logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc_expected_q [$];
   stim_row_type                        directed_rows [$];
   gap_mode_type                        gap_mode;
   int                                  fail_count;
   int                                  items_sent;
   int                                  results_checked;
   int                                  writes_done;

   crc_msb_first_multi_width_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc_after_byte(
         input logic [7:0] data, input logic first);
      int unsigned                         nbits;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] mask;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] topbit;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] poly;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] crc;
      case (cur_width_sel)
         crcmw_pkg::WIDTH_SEL_8:  nbits = 8;
         crcmw_pkg::WIDTH_SEL_16: nbits = 16;
         default:                 nbits = 32;
      endcase
      mask   = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
      topbit = 32'd1 << (nbits - 1);
      poly   = cur_poly & mask;
      // a mid-message width change truncates the running value too
      crc    = (first ? cur_init : crc_state) & mask;
      crc    = crc ^ ({24'd0, data} << (nbits - 8));
      for (int k = 0; k < 8; k++) begin
         if ((crc & topbit) != 0)
            crc = ((crc << 1) ^ poly) & mask;
         else
            crc = (crc << 1) & mask;
      end
      return crc;
   endfunction

   function automatic int gap_pct(input logic rx_side);
      case (gap_mode)
         GAPS_RX_HEAVY: return rx_side ? 49 : 16;
         GAPS_TX_HEAVY: return rx_side ? 16 : 49;
         default:       return 0;
      endcase
   endfunction

   function automatic stim_row_type item_row(input logic [7:0] data, input logic first,
                                             input logic last, input logic known,
                                             input logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] value);
      stim_row_type row;
      row.kind  = ROW_ITEM;
      row.data  = data;
      row.first = first;
      row.last  = last;
      row.known = known;
      row.value = value;
      row.index = '0;
      return row;
   endfunction

   function automatic stim_row_type csr_row(
         input logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0] index,
         input logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] value);
      stim_row_type row;
      row       = item_row(8'h00, 1'b0, 1'b0, 1'b0, value);
      row.kind  = ROW_CSR;
      row.index = index;
      return row;
   endfunction

   // called right after a rising edge; returns at the edge that took the item
   task automatic send_item(input logic [7:0] data, input logic first, input logic last,
                            input logic known,
                            input logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] known_crc);
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] next_crc;
      while ($urandom_range(99) < gap_pct(1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first;
      req_last_byte  <= last;
      do @(posedge clock); while (req_stall);
      next_crc  = crc_after_byte(data, first);
      crc_state = next_crc;
      if (last)
         crc_expected_q.push_back(known ? known_crc : next_crc);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (crc_expected_q.size() != 0)
         @(posedge clock);
      // a trailing item without last may still be updating the crc
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [crcmw_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] wdata);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= wdata;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         crcmw_pkg::CSR_WIDTH_SELECT:   cur_width_sel = wdata[1:0];
         crcmw_pkg::CSR_GENERATOR_POLY: cur_poly      = wdata;
         crcmw_pkg::CSR_INITIAL_VALUE:  cur_init      = wdata;
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
   endtask

   // result side: random stall, check every accepted crc in order
   always @(posedge clock) begin
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (crc_expected_q.size() == 0) begin
            $error("unexpected result: crc_value %08h", rsp_crc_value);
            fail_count++;
         end else begin
            want = crc_expected_q.pop_front();
            results_checked++;
            if (rsp_crc_value !== want) begin
               $error("crc_value mismatch: expected %08h, actual %08h", want, rsp_crc_value);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < gap_pct(1'b1));
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int                                  n_msgs;
      int                                  msg_len;
      logic                                first;
      logic                                last;
      logic [7:0]                          data;
      logic [1:0]                          width_code;
      logic [crcmw_pkg::CRC_MAX_WIDTH-1:0] wdata;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data_byte    <= 8'h00;
      req_first_byte   <= 1'b0;
      req_last_byte    <= 1'b0;
      rsp_stall        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= crcmw_pkg::CSR_WIDTH_SELECT;
      csr_write_data   <= '0;
      cur_width_sel    = crcmw_pkg::RESET_WIDTH_SELECT;
      cur_poly         = crcmw_pkg::RESET_GENERATOR_POLY;
      cur_init         = crcmw_pkg::RESET_INITIAL_VALUE;
      crc_state        = '0;
      gap_mode         = GAPS_RX_HEAVY;
      fail_count       = 0;
      items_sent       = 0;
      results_checked  = 0;
      writes_done      = 0;

      // directed: reset defaults, truncation, width changes, extreme polynomials
      directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000));
      directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1, 1'b1, 32'h04C1_1DB7));
      directed_rows.push_back(item_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
      directed_rows.push_back(item_row(8'hA5, 1'b1, 1'b0, 1'b0, '0));
      directed_rows.push_back(item_row(8'h5A, 1'b0, 1'b0, 1'b0, '0));
      directed_rows.push_back(item_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_WIDTH_SELECT,
                                      {30'h3FFF_FFFF, crcmw_pkg::WIDTH_SEL_8}));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_GENERATOR_POLY, 32'hFFFF_FF07));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_INITIAL_VALUE, 32'hFFFF_FF00));
      directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1, 1'b1, 32'h0000_0007));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_INITIAL_VALUE, 32'hFFFF_FFFF));
      directed_rows.push_back(item_row(8'h00, 1'b1, 1'b1, 1'b0, '0));
      directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b0, 1'b0, '0));
      directed_rows.push_back(item_row(8'h80, 1'b0, 1'b0, 1'b0, '0));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_WIDTH_SELECT,
                                      {30'd0, crcmw_pkg::WIDTH_SEL_16}));
      directed_rows.push_back(item_row(8'h12, 1'b0, 1'b1, 1'b0, '0));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_GENERATOR_POLY, 32'h0000_1021));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_INITIAL_VALUE, 32'h0000_0000));
      directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1, 1'b1, 32'h0000_1021));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_WIDTH_SELECT, 32'h0000_0003));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_GENERATOR_POLY, 32'hFFFF_FFFF));
      directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
      directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b1, 1'b0, '0));
      directed_rows.push_back(csr_row(CSR_UNUSED_INDEX, 32'h1234_5678));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_GENERATOR_POLY, 32'h0000_0000));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_INITIAL_VALUE, 32'hFFFF_FFFF));
      directed_rows.push_back(item_row(8'h00, 1'b1, 1'b1, 1'b0, '0));
      directed_rows.push_back(item_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_WIDTH_SELECT,
                                      {30'd0, crcmw_pkg::WIDTH_SEL_8}));
      directed_rows.push_back(csr_row(crcmw_pkg::CSR_GENERATOR_POLY, 32'h0000_00FF));
      directed_rows.push_back(item_row(8'h55, 1'b1, 1'b1, 1'b0, '0));
      directed_rows.push_back(item_row(8'hAA, 1'b0, 1'b1, 1'b0, '0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            csr_write(directed_rows[i].index, directed_rows[i].value);
         else
            send_item(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].value);
      end

      // random phases: new settings, then a burst of messages
      while (items_sent < RANDOM_ITEM_TARGET) begin
         width_code = 2'($urandom_range(3));
         wdata = $urandom();
         if ($urandom_range(1) == 0)
            wdata = '0;
         wdata[1:0] = width_code;
         csr_write(crcmw_pkg::CSR_WIDTH_SELECT, wdata);
         case ($urandom_range(5))
            0:       wdata = 32'h0000_0000;
            1:       wdata = 32'hFFFF_FFFF;
            2:       wdata = 32'h0000_0007;
            3:       wdata = 32'h0000_1021;
            4:       wdata = 32'h04C1_1DB7;
            default: wdata = $urandom();
         endcase
         csr_write(crcmw_pkg::CSR_GENERATOR_POLY, wdata);
         case ($urandom_range(3))
            0:       wdata = 32'h0000_0000;
            1:       wdata = 32'hFFFF_FFFF;
            default: wdata = $urandom();
         endcase
         csr_write(crcmw_pkg::CSR_INITIAL_VALUE, wdata);
         if ($urandom_range(7) == 0)
            csr_write(CSR_UNUSED_INDEX, $urandom());

         n_msgs = $urandom_range(1, 6);
         for (int m = 0; m < n_msgs; m++) begin
            msg_len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++) begin
               if (items_sent < 150)
                  gap_mode = GAPS_RX_HEAVY;
               else if (items_sent < 285)
                  gap_mode = GAPS_TX_HEAVY;
               else
                  gap_mode = GAPS_NONE;
               // mostly well-formed messages, a few stray or missing flags
               first = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0);
               if (i == msg_len - 1)
                  last = !(m == n_msgs - 1 && $urandom_range(4) == 0);
               else
                  last = ($urandom_range(39) == 0);
               case ($urandom_range(9))
                  0:       data = 8'h00;
                  1:       data = 8'hFF;
                  default: data = 8'($urandom());
               endcase
               send_item(data, first, last, 1'b0, '0);
            end
         end
      end

      wait_idle();
      $display("run covered %0d bytes, %0d crc results and %0d register writes",
               items_sent, results_checked, writes_done);
      $display("widths 8, 16, 32 and code 3, extreme polynomials and seeds, both stall sides");
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/crcmw_pkg.sv
rtl/core/crcmw_csr.sv
rtl/core/crcmw_update.sv
rtl/core/crc_msb_first_multi_width_unit.sv
verif/crc_msb_first_multi_width_unit_tb.sv
